// ===== rtl/core/cmac_pkg.sv =====
`default_nettype none
package cmac_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_MIN_X0    = 3'd0;
	localparam logic [2:0] REG_MAX_X0    = 3'd1;
	localparam logic [2:0] REG_MIN_X1    = 3'd2;
	localparam logic [2:0] REG_MAX_X1    = 3'd3;
	localparam logic [2:0] REG_RATE      = 3'd4;
	localparam logic [2:0] REG_OFFS_X0   = 3'd5;
	localparam logic [2:0] REG_OFFS_X1   = 3'd6;

	localparam int CFG_W   = 16;
	localparam int OFFS_W  = 15;
	localparam int WGT_W   = 24;
	localparam int DISP_LAYERS = 5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_DIV,
		ST_ADDR,
		ST_READ,
		ST_SUM,
		ST_INC,
		ST_WRITE,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture item, start dividers
		logic div_step;   // one quotient bit per cycle
		logic addr_calc;  // form index of current layer
		logic rd_issue;   // read weights at current index
		logic acc;        // accumulate read data
		logic inc_calc;   // compute training increments
		logic rd_upd;     // read weight for update
		logic wr_upd;     // write updated weight
		logic clr_wr;     // clearing write at clear address
		logic done;       // present result
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_last;
		logic clr_last;
		logic train;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/cmac_lookup_and_train.sv =====
// Two-input, two-output CMAC. Pulse start while busy is low; one result appears
// on pred_0/pred_1/range_error for exactly one cycle with strobe high, and the
// receiver cannot stall it. After the transfer busy stays high through the
// shift-subtract quantizer dividers (clog2(RESOLUTION)+17 quotient bits), then
// an address, read and sum step per association layer for the weight reads
// (single read port per table), plus an increment-and-read and a write step per
// layer in train mode for read-modify-write, plus a step to present the result.
// The strobe is raised in the same cycle that busy drops. After
// reset the weight tables are swept to zero one entry per cycle (all R*R
// entries, 121 by default) with busy high.
// Configuration writes are taken at any time and should be made while idle.
`default_nettype none
module cmac_lookup_and_train #(
	parameter int RESOLUTION = 50,
	parameter int N_ASSOC    = 5
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire                cfg_we,
	input  wire [2:0]          cfg_idx,
	input  wire [15:0]         cfg_data,
	input  wire                mode,
	input  wire signed [15:0]  sample_x0,
	input  wire signed [15:0]  sample_x1,
	input  wire signed [15:0]  target_0,
	input  wire signed [15:0]  target_1,
	output logic               strobe,
	output logic signed [15:0] pred_0,
	output logic signed [15:0] pred_1,
	output logic               range_error
);

	cmac_pkg::dp_cmd_t  cmd;
	cmac_pkg::dp_stat_t stat;
	logic [$clog2(N_ASSOC+1)-1:0] layer;

	cmac_ctrl #(.N_ASSOC(N_ASSOC)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.stat(stat), .cmd(cmd), .layer(layer)
	);

	cmac_dp #(.RESOLUTION(RESOLUTION), .N_ASSOC(N_ASSOC)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .layer(layer),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.mode(mode), .sample_x0(sample_x0), .sample_x1(sample_x1),
		.target_0(target_0), .target_1(target_1),
		.strobe(strobe), .pred_0(pred_0), .pred_1(pred_1),
		.range_error(range_error)
	);

endmodule
`default_nettype wire

// ===== rtl/core/cmac_ram.sv =====
`default_nettype none
module cmac_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 121
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/core/cmac_ctrl.sv =====
`default_nettype none
module cmac_ctrl #(
	parameter int N_ASSOC = 5
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  cmac_pkg::dp_stat_t   stat,
	output cmac_pkg::dp_cmd_t    cmd,
	output logic [$clog2(N_ASSOC+1)-1:0] layer
);

	localparam int LW = $clog2(N_ASSOC + 1);
	localparam logic [LW-1:0] LAST = LW'(N_ASSOC - 1);

	cmac_pkg::state_t state_q, state_d;
	logic [LW-1:0] layer_q, layer_d;

	assign layer = layer_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cmac_pkg::ST_CLEAR;
			layer_q <= '0;
		end else begin
			state_q <= state_d;
			layer_q <= layer_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		layer_d = layer_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			cmac_pkg::ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_d = cmac_pkg::ST_IDLE;
				end
			end
			cmac_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = cmac_pkg::ST_DIV;
				end
			end
			cmac_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					layer_d = '0;
					state_d = cmac_pkg::ST_ADDR;
				end
			end
			cmac_pkg::ST_ADDR: begin
				cmd.addr_calc = 1'b1;
				state_d = cmac_pkg::ST_READ;
			end
			cmac_pkg::ST_READ: begin
				cmd.rd_issue = 1'b1;
				state_d = cmac_pkg::ST_SUM;
			end
			cmac_pkg::ST_SUM: begin
				cmd.acc = 1'b1;
				if (layer_q == LAST) begin
					layer_d = '0;
					state_d = stat.train ? cmac_pkg::ST_INC : cmac_pkg::ST_DONE;
				end else begin
					layer_d = layer_q + 1'b1;
					state_d = cmac_pkg::ST_ADDR;
				end
			end
			cmac_pkg::ST_INC: begin
				// issue read for current layer, increments form in parallel
				cmd.inc_calc = 1'b1;
				cmd.rd_upd   = 1'b1;
				state_d = cmac_pkg::ST_WRITE;
			end
			cmac_pkg::ST_WRITE: begin
				cmd.wr_upd = 1'b1;
				if (layer_q == LAST) begin
					state_d = cmac_pkg::ST_DONE;
				end else begin
					layer_d = layer_q + 1'b1;
					state_d = cmac_pkg::ST_INC;
				end
			end
			cmac_pkg::ST_DONE: begin
				cmd.done = 1'b1;
				state_d = cmac_pkg::ST_IDLE;
			end
			default: begin
				state_d = cmac_pkg::ST_IDLE;
			end
		endcase
	end

	// at most one of the listed datapath phases at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.div_step, cmd.rd_issue, cmd.acc, cmd.wr_upd,
			cmd.clr_wr, cmd.done}))
		else $error("overlapping datapath commands");
	// a write never happens while idle
	assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !cmd.wr_upd && !cmd.clr_wr)
		else $error("weight write while idle");
	// a result follows a write or accumulate phase
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.done |-> $past(cmd.wr_upd) || $past(cmd.acc))
		else $error("result without completed lookup");

endmodule
`default_nettype wire

// ===== rtl/core/cmac_dp.sv =====
`default_nettype none
module cmac_dp #(
	parameter int RESOLUTION = 50,
	parameter int N_ASSOC    = 5
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  cmac_pkg::dp_cmd_t    cmd,
	output cmac_pkg::dp_stat_t   stat,
	input  wire [$clog2(N_ASSOC+1)-1:0] layer,
	input  wire                  cfg_we,
	input  wire [2:0]            cfg_idx,
	input  wire [15:0]           cfg_data,
	input  wire                  mode,
	input  wire signed [15:0]    sample_x0,
	input  wire signed [15:0]    sample_x1,
	input  wire signed [15:0]    target_0,
	input  wire signed [15:0]    target_1,
	output logic                 strobe,
	output logic signed [15:0]   pred_0,
	output logic signed [15:0]   pred_1,
	output logic                 range_error
);

	localparam int R     = (RESOLUTION - 2) / N_ASSOC + 2;
	localparam int DEPTH = R * R;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(R);
	localparam int QW    = $clog2(RESOLUTION);
	localparam int LW    = $clog2(N_ASSOC + 1);
	// dividend = RESOLUTION*d, up to RESOLUTION*65535
	localparam int NW    = $clog2(RESOLUTION) + 17;
	localparam int NCW   = $clog2(NW + 1);
	localparam int WW    = cmac_pkg::WGT_W;
	localparam int SW    = WW + LW + 1;
	localparam int PW    = QW + 4;
	// coarse coordinate: divide by N_ASSOC through a rounded-up reciprocal
	localparam int DSH   = PW + 4;
	localparam int DRCP  = ((1 << DSH) + N_ASSOC - 1) / N_ASSOC;
	localparam int DMW   = PW + DSH + 1;
	// increment: offset the shifted product to non-negative, then reciprocal
	localparam int ISH   = 25;
	localparam longint IRCP = ((64'd1 << ISH) + N_ASSOC - 1) / N_ASSOC;
	localparam int IOFS  = N_ASSOC << 17;

	// configuration registers
	logic signed [15:0] min0_q, max0_q, min1_q, max1_q;
	logic [15:0] rate_q;
	logic [cmac_pkg::OFFS_W-1:0] offs0_q, offs1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min0_q  <= '0;
			max0_q  <= 16'sd32767;
			min1_q  <= '0;
			max1_q  <= 16'sd32767;
			rate_q  <= 16'd19661;
			offs0_q <= '0;
			offs1_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				cmac_pkg::REG_MIN_X0:  min0_q  <= cfg_data;
				cmac_pkg::REG_MAX_X0:  max0_q  <= cfg_data;
				cmac_pkg::REG_MIN_X1:  min1_q  <= cfg_data;
				cmac_pkg::REG_MAX_X1:  max1_q  <= cfg_data;
				cmac_pkg::REG_RATE:    rate_q  <= cfg_data;
				cmac_pkg::REG_OFFS_X0: offs0_q <= cfg_data[cmac_pkg::OFFS_W-1:0];
				cmac_pkg::REG_OFFS_X1: offs1_q <= cfg_data[cmac_pkg::OFFS_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp and span for each input
	logic bad0, bad1;
	logic signed [16:0] cl0, cl1;
	logic [16:0] d0, d1, span0, span1;
	always_comb begin
		bad0 = (max0_q <= min0_q);
		bad1 = (max1_q <= min1_q);
		cl0 = (sample_x0 > max0_q) ? 17'(max0_q) :
			(sample_x0 < min0_q) ? 17'(min0_q) : 17'(sample_x0);
		cl1 = (sample_x1 > max1_q) ? 17'(max1_q) :
			(sample_x1 < min1_q) ? 17'(min1_q) : 17'(sample_x1);
		d0 = 17'(cl0 - 17'(min0_q));
		d1 = 17'(cl1 - 17'(min1_q));
		span0 = 17'(17'(max0_q) - 17'(min0_q));
		span1 = 17'(17'(max1_q) - 17'(min1_q));
	end

	// restoring dividers, one quotient bit per cycle
	logic [NW-1:0] num0_q, num1_q, quo0_q, quo1_q;
	logic [17:0] rem0_q, rem1_q;
	logic [16:0] den0_q, den1_q;
	logic [NCW-1:0] dcnt_q;
	logic bad0_q, bad1_q, train_q;
	logic signed [15:0] tgt0_q, tgt1_q;
	logic [17:0] r0n, r1n;
	logic [18:0] t0, t1;

	always_comb begin
		r0n = {rem0_q[16:0], num0_q[NW-1]};
		r1n = {rem1_q[16:0], num1_q[NW-1]};
		t0  = {1'b0, r0n} - {2'b0, den0_q};
		t1  = {1'b0, r1n} - {2'b0, den1_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.load) begin
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num0_q  <= NW'(RESOLUTION) * NW'(d0);
			num1_q  <= NW'(RESOLUTION) * NW'(d1);
			den0_q  <= span0;
			den1_q  <= span1;
			rem0_q  <= '0;
			rem1_q  <= '0;
			quo0_q  <= '0;
			quo1_q  <= '0;
			bad0_q  <= bad0;
			bad1_q  <= bad1;
			train_q <= mode;
			tgt0_q  <= target_0;
			tgt1_q  <= target_1;
		end else if (cmd.div_step) begin
			num0_q <= {num0_q[NW-2:0], 1'b0};
			num1_q <= {num1_q[NW-2:0], 1'b0};
			if (!t0[18]) begin
				rem0_q <= t0[17:0];
				quo0_q <= {quo0_q[NW-2:0], 1'b1};
			end else begin
				rem0_q <= r0n;
				quo0_q <= {quo0_q[NW-2:0], 1'b0};
			end
			if (!t1[18]) begin
				rem1_q <= t1[17:0];
				quo1_q <= {quo1_q[NW-2:0], 1'b1};
			end else begin
				rem1_q <= r1n;
				quo1_q <= {quo1_q[NW-2:0], 1'b0};
			end
		end
	end

	assign stat.div_last = (dcnt_q == NCW'(NW - 1));
	assign stat.train    = train_q;

	// quantized levels
	logic [QW-1:0] q0, q1;
	always_comb begin
		q0 = bad0_q ? '0 : (quo0_q >= NW'(RESOLUTION)) ? QW'(RESOLUTION - 1)
			: quo0_q[QW-1:0];
		q1 = bad1_q ? '0 : (quo1_q >= NW'(RESOLUTION)) ? QW'(RESOLUTION - 1)
			: quo1_q[QW-1:0];
	end

	// coarse coordinates for the current layer
	logic [2:0] disp0, disp1;
	logic [PW-1:0] v0, v1, p0, p1;
	logic [DMW-1:0] m0, m1;
	logic [CW-1:0] c0, c1;
	logic [AW-1:0] idx_d;
	always_comb begin
		disp0 = '0;
		disp1 = '0;
		for (int i = 0; i < cmac_pkg::DISP_LAYERS; i++) begin
			if (32'(layer) == i) begin
				disp0 = offs0_q[3*i +: 3];
				disp1 = offs1_q[3*i +: 3];
			end
		end
		v0 = PW'(q0) + PW'(disp0);
		v1 = PW'(q1) + PW'(disp1);
		m0 = DMW'(v0) * DMW'(DRCP);
		m1 = DMW'(v1) * DMW'(DRCP);
		p0 = PW'(m0 >> DSH);
		p1 = PW'(m1 >> DSH);
		c0 = (p0 > PW'(R - 1)) ? CW'(R - 1) : p0[CW-1:0];
		c1 = (p1 > PW'(R - 1)) ? CW'(R - 1) : p1[CW-1:0];
		idx_d = AW'(AW'(c0) * AW'(R)) + AW'(c1);
	end

	logic [AW-1:0] idx_q;
	always_ff @(posedge clk) begin
		if (cmd.addr_calc || cmd.inc_calc) begin
			idx_q <= idx_d;
		end
	end

	// clear sweep address
	logic [AW-1:0] clr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + 1'b1;
		end
	end
	assign stat.clr_last = (clr_q == AW'(DEPTH - 1));

	// weight memories; in update phase the read uses the live index, the write the held copy of it
	logic [WW-1:0] rd0, rd1, wd0, wd1;
	logic we;
	logic [AW-1:0] waddr, raddr;
	assign we    = cmd.clr_wr || cmd.wr_upd;
	assign waddr = cmd.clr_wr ? clr_q : idx_q;
	assign raddr = (cmd.rd_upd) ? idx_d : idx_q;

	cmac_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_ram0 (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wd0), .raddr(raddr), .rdata(rd0)
	);
	cmac_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_ram1 (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wd1), .raddr(raddr), .rdata(rd1)
	);

	// prediction sums
	logic signed [SW-1:0] sum0_q, sum1_q;
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sum0_q <= '0;
			sum1_q <= '0;
		end else if (cmd.acc) begin
			sum0_q <= sum0_q + SW'($signed(rd0));
			sum1_q <= sum1_q + SW'($signed(rd1));
		end
	end

	logic signed [15:0] sp0, sp1;
	always_comb begin
		sp0 = (sum0_q > SW'(32767)) ? 16'sd32767 :
			(sum0_q < -SW'(32768)) ? -16'sd32768 : 16'(sum0_q);
		sp1 = (sum1_q > SW'(32767)) ? 16'sd32767 :
			(sum1_q < -SW'(32768)) ? -16'sd32768 : 16'(sum1_q);
	end

	// training increments: floor(rate*err / (65536*N_ASSOC))
	logic signed [16:0] err0, err1;
	logic signed [33:0] prod0_q, prod1_q;
	assign err0 = 17'(tgt0_q) - 17'(sp0);
	assign err1 = 17'(tgt1_q) - 17'(sp1);
	always_ff @(posedge clk) begin
		if (cmd.inc_calc && layer == '0) begin
			prod0_q <= $signed({1'b0, rate_q}) * err0;
			prod1_q <= $signed({1'b0, rate_q}) * err1;
		end
	end

	// floor by 65536 is an arithmetic shift, then floor by N_ASSOC on an offset value
	function automatic logic signed [WW-1:0] fdiv(input logic signed [33:0] x);
		logic signed [17:0] y;
		logic [20:0] yo;
		logic [46:0] pm;
		logic [21:0] qo;
		begin
			y    = x[33:16];
			yo   = 21'(y) + 21'(IOFS);
			pm   = 47'(yo) * 47'(IRCP);
			qo   = 22'(pm >> ISH);
			fdiv = WW'(qo) - WW'(32'(1 << 17));
		end
	endfunction

	logic signed [WW-1:0] inc0, inc1;
	assign inc0 = fdiv(prod0_q);
	assign inc1 = fdiv(prod1_q);

	logic signed [WW:0] s0w, s1w;
	always_comb begin
		s0w = (WW+1)'($signed(rd0)) + (WW+1)'(inc0);
		s1w = (WW+1)'($signed(rd1)) + (WW+1)'(inc1);
		if (cmd.clr_wr) begin
			wd0 = '0;
			wd1 = '0;
		end else begin
			wd0 = (s0w[WW] != s0w[WW-1]) ? {s0w[WW], {(WW-1){~s0w[WW]}}} : s0w[WW-1:0];
			wd1 = (s1w[WW] != s1w[WW-1]) ? {s1w[WW], {(WW-1){~s1w[WW]}}} : s1w[WW-1:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= cmd.done;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.done) begin
			pred_0      <= sp0;
			pred_1      <= sp1;
			range_error <= bad0_q | bad1_q;
		end
	end

	// a write in the update phase always follows its own read
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_upd |-> $past(cmd.rd_upd))
		else $error("update write without read");
	// update writes the entry that was just read
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_upd |-> waddr == $past(raddr))
		else $error("update index moved");
	// divider finishes before lookup
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.addr_calc && layer == '0 |-> stat.div_last || $past(stat.div_last))
		else $error("lookup before division done");

endmodule
`default_nettype wire
